// File: rtl/core/hgbf_pkg.sv
// ----------------------------------------------------------------------------
// Height grid bilinear force: shared package
// Types, register indexes, state codes and saturation helpers used by the
// height grid query engine and its sub-units.
// ----------------------------------------------------------------------------
package hgbf_pkg;

    localparam int MAX_ROWS   = 128;
    localparam int MAX_COLS   = 128;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int CFG_IDX_W  = 4;
    localparam int ACC_W      = 66;
    localparam int MUL_A_W    = 35;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_CELL   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SCALE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_POT_MODE    = 4'd7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Sample points of one query: center, then +x, -x, +y, -y.
    localparam logic [2:0] SMP_CENTER = 3'd0;
    localparam logic [2:0] SMP_XP     = 3'd1;
    localparam logic [2:0] SMP_XM     = 3'd2;
    localparam logic [2:0] SMP_YP     = 3'd3;
    localparam logic [2:0] SMP_YM     = 3'd4;
    localparam logic [2:0] SMP_LAST   = SMP_YM;

    typedef struct packed {
        logic               opcode;
        logic [6:0]         cell_row;
        logic [6:0]         cell_col;
        logic signed [31:0] cell_height;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] point_potential;
        logic signed [47:0] total_potential;
        logic               total_valid;
    } t_out_item;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SR16,
        ACC_ADD_SL16,
        ACC_ADD_SL17
    } t_acc_op;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
        t_acc_op                   op;
    } t_mac_cmd;

    typedef enum logic [31:0] {
        ST_IDLE  = 32'h0000_0001,
        ST_SETUP = 32'h0000_0002,
        ST_PX0   = 32'h0000_0004,
        ST_PX1   = 32'h0000_0008,
        ST_PY0   = 32'h0000_0010,
        ST_PY1   = 32'h0000_0020,
        ST_PW    = 32'h0000_0040,
        ST_PC    = 32'h0000_0080,
        ST_RD0   = 32'h0000_0100,
        ST_RD1   = 32'h0000_0200,
        ST_RD2   = 32'h0000_0400,
        ST_RD3   = 32'h0000_0800,
        ST_BL0   = 32'h0000_1000,
        ST_BL1   = 32'h0000_2000,
        ST_BL2   = 32'h0000_4000,
        ST_BL3   = 32'h0000_8000,
        ST_BL4   = 32'h0001_0000,
        ST_BL5   = 32'h0002_0000,
        ST_EL    = 32'h0004_0000,
        ST_G0    = 32'h0008_0000,
        ST_G1    = 32'h0010_0000,
        ST_G2    = 32'h0020_0000,
        ST_G3    = 32'h0040_0000,
        ST_G4    = 32'h0080_0000,
        ST_G5    = 32'h0100_0000,
        ST_G6    = 32'h0200_0000,
        ST_G7    = 32'h0400_0000,
        ST_G8    = 32'h0800_0000,
        ST_G9    = 32'h1000_0000,
        ST_G10   = 32'h2000_0000,
        ST_G11   = 32'h4000_0000,
        ST_OUT   = 32'h8000_0000
    } t_state;

    // A size of zero acts as one, anything above the maximum as the maximum.
    function automatic logic [7:0] eff_size(input logic [7:0] v, input logic [7:0] maxv);
        logic [7:0] r;
        if (v == 8'd0) begin
            r = 8'd1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > $signed({{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF})) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000})) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        logic signed [47:0] r;
        if (v > $signed({3'b000, 48'h7FFF_FFFF_FFFF})) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < $signed({3'b111, 48'h8000_0000_0000})) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/height_grid_bilinear_force_top.sv
// ----------------------------------------------------------------------------
// Height grid bilinear force: top level
// A query works through five bilinear samples, paced by the single
// multiplier and the single memory port, then through gradient, force,
// potential and result. One query is in work at a time, so no new item
// is taken until its result is registered, and a stalled result holds the
// next one back.
// Reset (synchronous, active low) restores the registers and the running
// lowest, highest and sum; the height store keeps its contents.
// ----------------------------------------------------------------------------
module height_grid_bilinear_force_top import hgbf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Item input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    // Result output channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // Configuration registers.
    logic [7:0]         r_grid_cols;
    logic [7:0]         r_grid_rows;
    logic signed [31:0] r_origin_x;
    logic signed [31:0] r_origin_y;
    logic [31:0]        r_inv_cell;
    logic [30:0]        r_half_cell;
    logic signed [31:0] r_force_scale;
    logic               r_pot_mode;

    // Running grid state.
    logic signed [31:0] r_lowest;
    logic signed [31:0] r_highest;
    logic signed [47:0] r_sum;
    logic               r_written;

    // Query working registers.
    t_state             r_state;
    t_state             n_state;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;
    logic               r_last;
    logic               r_zero;
    logic [2:0]         r_smp;
    logic [33:0]        r_dx;
    logic [33:0]        r_dy;
    logic [22:0]        r_fx;
    logic [22:0]        r_fy;
    logic signed [48:0] r_lo;
    logic signed [48:0] r_hi;
    logic signed [31:0] r_elev [5];
    logic signed [31:0] r_gx;
    logic signed [31:0] r_gy;
    logic signed [49:0] r_p;
    logic signed [31:0] r_fxo;
    logic signed [31:0] r_fyo;

    // Output register.
    logic               r_ovalid;
    t_out_item          r_odata;

    logic               in_xfer;
    logic               out_free;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic signed [31:0] mem_rdata;
    t_mac_cmd           mac_cmd;
    logic signed [ACC_W-1:0] acc;

    // The input is taken only while no query is in work; a write completes in
    // the cycle of its transfer.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_ovalid || !i_out_stall;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols   <= 8'd128;
            r_grid_rows   <= 8'd128;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_inv_cell    <= 32'h0001_0000;
            r_half_cell   <= 31'h0000_8000;
            r_force_scale <= 32'sh0001_0000;
            r_pot_mode    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRID_COLS:   r_grid_cols   <= i_cfg_data[7:0];
                CFG_GRID_ROWS:   r_grid_rows   <= i_cfg_data[7:0];
                CFG_ORIGIN_X:    r_origin_x    <= i_cfg_data;
                CFG_ORIGIN_Y:    r_origin_y    <= i_cfg_data;
                CFG_INV_CELL:    r_inv_cell    <= i_cfg_data;
                CFG_HALF_CELL:   r_half_cell   <= i_cfg_data[30:0];
                CFG_FORCE_SCALE: r_force_scale <= i_cfg_data;
                CFG_POT_MODE:    r_pot_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sample point and grid position arithmetic
    // ------------------------------------------------------------------
    logic [7:0]         cols_e;
    logic [7:0]         rows_e;
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [33:0] dx_s;
    logic signed [33:0] dy_s;
    logic [22:0]        lim_x;
    logic [22:0]        lim_y;
    logic [22:0]        pos_clamped;
    logic [6:0]         c0;
    logic [6:0]         c1;
    logic [6:0]         rw0;
    logic [6:0]         rw1;
    logic [7:0]         c0_inc;
    logic [7:0]         r0_inc;
    logic [7:0]         cols_m1;
    logic [7:0]         rows_m1;
    logic [16:0]        wx0;
    logic [16:0]        wx1;
    logic [16:0]        wy0;
    logic [16:0]        wy1;

    assign cols_e  = eff_size(r_grid_cols, 8'(MAX_COLS));
    assign rows_e  = eff_size(r_grid_rows, 8'(MAX_ROWS));
    assign cols_m1 = cols_e - 8'd1;
    assign rows_m1 = rows_e - 8'd1;
    assign lim_x   = {cols_m1[6:0], 16'h0000};
    assign lim_y   = {rows_m1[6:0], 16'h0000};

    always_comb begin
        xs = {r_pos_x[31], r_pos_x};
        ys = {r_pos_y[31], r_pos_y};
        unique case (r_smp)
            SMP_XP:  xs = {r_pos_x[31], r_pos_x} + {2'b00, r_half_cell};
            SMP_XM:  xs = {r_pos_x[31], r_pos_x} - {2'b00, r_half_cell};
            SMP_YP:  ys = {r_pos_y[31], r_pos_y} + {2'b00, r_half_cell};
            SMP_YM:  ys = {r_pos_y[31], r_pos_y} - {2'b00, r_half_cell};
            default: ;
        endcase
    end

    assign dx_s = {xs[32], xs} - {{2{r_origin_x[31]}}, r_origin_x};
    assign dy_s = {ys[32], ys} - {{2{r_origin_y[31]}}, r_origin_y};

    // The accumulator holds a non-negative grid position; clamp it to the
    // last cell of the axis in use (x in PY1, y in PC).
    always_comb begin
        logic [22:0] lim;
        lim = (r_state == ST_PY1) ? lim_x : lim_y;
        if (acc > $signed({{(ACC_W-23){1'b0}}, lim})) begin
            pos_clamped = lim;
        end else begin
            pos_clamped = acc[22:0];
        end
    end

    assign c0     = r_fx[22:16];
    assign rw0    = r_fy[22:16];
    assign c0_inc = {1'b0, c0} + 8'd1;
    assign r0_inc = {1'b0, rw0} + 8'd1;
    assign c1     = (c0_inc < cols_e) ? c0_inc[6:0] : cols_m1[6:0];
    assign rw1    = (r0_inc < rows_e) ? r0_inc[6:0] : rows_m1[6:0];
    assign wx1    = {1'b0, r_fx[15:0]};
    assign wy1    = {1'b0, r_fy[15:0]};
    assign wx0    = 17'h1_0000 - wx1;
    assign wy0    = 17'h1_0000 - wy1;

    // ------------------------------------------------------------------
    // Gradient, force and potential operands
    // ------------------------------------------------------------------
    logic signed [32:0] dgx;
    logic signed [32:0] dgy;
    logic signed [32:0] neg_dgx;
    logic signed [32:0] neg_dgy;
    logic [32:0]        mag_x;
    logic [32:0]        mag_y;
    logic signed [32:0] pdiff;
    logic signed [31:0] pot_ref;
    logic signed [31:0] grad_cap;
    logic               grad_neg;
    logic signed [ACC_W-1:0] force_rnd;
    logic signed [ACC_W-1:0] pot_rnd;
    logic signed [ACC_W-1:0] elev_rnd;

    assign dgx     = {r_elev[SMP_XP][31], r_elev[SMP_XP]} - {r_elev[SMP_XM][31], r_elev[SMP_XM]};
    assign dgy     = {r_elev[SMP_YP][31], r_elev[SMP_YP]} - {r_elev[SMP_YM][31], r_elev[SMP_YM]};
    assign neg_dgx = -dgx;
    assign neg_dgy = -dgy;
    assign mag_x   = dgx[32] ? neg_dgx : dgx;
    assign mag_y   = dgy[32] ? neg_dgy : dgy;
    assign pot_ref = r_pot_mode ? r_highest : r_lowest;
    assign pdiff   = {r_elev[SMP_CENTER][31], r_elev[SMP_CENTER]} - {pot_ref[31], pot_ref};

    // Signed gradient from the non-negative magnitude in the accumulator,
    // saturated to 32 bits (x in G3, y in G5).
    always_comb begin
        logic [31:0] g_low;
        grad_neg = (r_state == ST_G3) ? dgx[32] : dgy[32];
        g_low    = acc[31:0];
        if (!grad_neg) begin
            if (acc > $signed({{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF})) begin
                grad_cap = 32'sh7FFF_FFFF;
            end else begin
                grad_cap = g_low;
            end
        end else begin
            if (acc > $signed({{(ACC_W-33){1'b0}}, 33'h0_8000_0000})) begin
                grad_cap = 32'sh8000_0000;
            end else begin
                grad_cap = -g_low;
            end
        end
    end

    assign force_rnd = (-acc + 66'sd32768) >>> 16;
    assign pot_rnd   = (acc + 66'sd32768) >>> 16;
    assign elev_rnd  = acc + 66'sd2147483648;

    // ------------------------------------------------------------------
    // Multiplier command: one product per cycle, accumulated in the cycle after it is issued.
    // ------------------------------------------------------------------
    logic signed [MUL_A_W-1:0] a_rd;
    logic signed [MUL_B_W-1:0] b_ihi;
    logic signed [MUL_B_W-1:0] b_ilo;
    logic signed [MUL_B_W-1:0] b_shi;
    logic signed [MUL_B_W-1:0] b_slo;

    assign a_rd  = {{(MUL_A_W-32){mem_rdata[31]}}, mem_rdata};
    assign b_ihi = {2'b00, r_inv_cell[31:16]};
    assign b_ilo = {2'b00, r_inv_cell[15:0]};
    assign b_shi = {{2{r_force_scale[31]}}, r_force_scale[31:16]};
    assign b_slo = {2'b00, r_force_scale[15:0]};

    always_comb begin
        mac_cmd.a  = '0;
        mac_cmd.b  = '0;
        mac_cmd.op = ACC_HOLD;
        unique case (r_state)
            ST_PX0: begin
                mac_cmd.a = {1'b0, r_dx}; mac_cmd.b = b_ihi; mac_cmd.op = ACC_LOAD;
            end
            ST_PX1: begin
                mac_cmd.a = {1'b0, r_dx}; mac_cmd.b = b_ilo; mac_cmd.op = ACC_ADD_SR16;
            end
            ST_PY0: begin
                mac_cmd.a = {1'b0, r_dy}; mac_cmd.b = b_ihi; mac_cmd.op = ACC_LOAD;
            end
            ST_PY1: begin
                mac_cmd.a = {1'b0, r_dy}; mac_cmd.b = b_ilo; mac_cmd.op = ACC_ADD_SR16;
            end
            ST_RD1: begin
                mac_cmd.a = a_rd; mac_cmd.b = {1'b0, wx0}; mac_cmd.op = ACC_LOAD;
            end
            ST_RD2: begin
                mac_cmd.a = a_rd; mac_cmd.b = {1'b0, wx1}; mac_cmd.op = ACC_ADD;
            end
            ST_RD3: begin
                mac_cmd.a = a_rd; mac_cmd.b = {1'b0, wx0}; mac_cmd.op = ACC_LOAD;
            end
            ST_BL0: begin
                mac_cmd.a = a_rd; mac_cmd.b = {1'b0, wx1}; mac_cmd.op = ACC_ADD;
            end
            ST_BL1: begin
                mac_cmd.a  = {{(MUL_A_W-17){1'b0}}, r_lo[16:0]};
                mac_cmd.b  = {1'b0, wy0};
                mac_cmd.op = ACC_LOAD;
            end
            ST_BL2: begin
                mac_cmd.a  = {{(MUL_A_W-32){r_lo[48]}}, r_lo[48:17]};
                mac_cmd.b  = {1'b0, wy0};
                mac_cmd.op = ACC_ADD_SL17;
            end
            ST_BL3: begin
                mac_cmd.a  = {{(MUL_A_W-17){1'b0}}, r_hi[16:0]};
                mac_cmd.b  = {1'b0, wy1};
                mac_cmd.op = ACC_ADD;
            end
            ST_BL4: begin
                mac_cmd.a  = {{(MUL_A_W-32){r_hi[48]}}, r_hi[48:17]};
                mac_cmd.b  = {1'b0, wy1};
                mac_cmd.op = ACC_ADD_SL17;
            end
            ST_G0: begin
                mac_cmd.a = {2'b00, mag_x}; mac_cmd.b = b_ihi; mac_cmd.op = ACC_LOAD;
            end
            ST_G1: begin
                mac_cmd.a = {2'b00, mag_x}; mac_cmd.b = b_ilo; mac_cmd.op = ACC_ADD_SR16;
            end
            ST_G2: begin
                mac_cmd.a = {2'b00, mag_y}; mac_cmd.b = b_ihi; mac_cmd.op = ACC_LOAD;
            end
            ST_G3: begin
                mac_cmd.a = {2'b00, mag_y}; mac_cmd.b = b_ilo; mac_cmd.op = ACC_ADD_SR16;
            end
            ST_G4: begin
                mac_cmd.a = {{2{pdiff[32]}}, pdiff}; mac_cmd.b = b_slo; mac_cmd.op = ACC_LOAD;
            end
            ST_G5: begin
                mac_cmd.a = {{2{pdiff[32]}}, pdiff}; mac_cmd.b = b_shi;
                mac_cmd.op = ACC_ADD_SL16;
            end
            ST_G6: begin
                mac_cmd.a = {{3{r_gx[31]}}, r_gx}; mac_cmd.b = b_slo; mac_cmd.op = ACC_LOAD;
            end
            ST_G7: begin
                mac_cmd.a = {{3{r_gx[31]}}, r_gx}; mac_cmd.b = b_shi; mac_cmd.op = ACC_ADD_SL16;
            end
            ST_G8: begin
                mac_cmd.a = {{3{r_gy[31]}}, r_gy}; mac_cmd.b = b_slo; mac_cmd.op = ACC_LOAD;
            end
            ST_G9: begin
                mac_cmd.a = {{3{r_gy[31]}}, r_gy}; mac_cmd.b = b_shi; mac_cmd.op = ACC_ADD_SL16;
            end
            default: ;
        endcase
    end

    hgbf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .o_acc   (acc)
    );

    // ------------------------------------------------------------------
    // Height store: written on a write transfer, read at the four corners
    // of the current sample.
    // ------------------------------------------------------------------
    assign mem_we = in_xfer && (i_in_data.opcode == OP_WRITE);

    always_comb begin
        unique case (r_state)
            ST_RD0:  mem_addr = {rw0, c0};
            ST_RD1:  mem_addr = {rw0, c1};
            ST_RD2:  mem_addr = {rw1, c0};
            ST_RD3:  mem_addr = {rw1, c1};
            default: mem_addr = {i_in_data.cell_row, i_in_data.cell_col};
        endcase
    end

    hgbf_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_in_data.cell_height),
        .o_rdata (mem_rdata)
    );

    // Running lowest and highest are never undone by a rewrite.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= 32'sh7FFF_FFFF;
            r_highest <= 32'sh8000_0000;
            r_written <= 1'b0;
        end else if (mem_we) begin
            if (i_in_data.cell_height < r_lowest) begin
                r_lowest <= i_in_data.cell_height;
            end
            if (i_in_data.cell_height > r_highest) begin
                r_highest <= i_in_data.cell_height;
            end
            r_written <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_in_data.opcode == OP_QUERY)) begin
                    n_state = r_written ? ST_SETUP : ST_OUT;
                end
            end
            ST_SETUP: n_state = ST_PX0;
            ST_PX0:   n_state = ST_PX1;
            ST_PX1:   n_state = ST_PY0;
            ST_PY0:   n_state = ST_PY1;
            ST_PY1:   n_state = ST_PW;
            ST_PW:    n_state = ST_PC;
            ST_PC:    n_state = ST_RD0;
            ST_RD0:   n_state = ST_RD1;
            ST_RD1:   n_state = ST_RD2;
            ST_RD2:   n_state = ST_RD3;
            ST_RD3:   n_state = ST_BL0;
            ST_BL0:   n_state = ST_BL1;
            ST_BL1:   n_state = ST_BL2;
            ST_BL2:   n_state = ST_BL3;
            ST_BL3:   n_state = ST_BL4;
            ST_BL4:   n_state = ST_BL5;
            ST_BL5:   n_state = ST_EL;
            ST_EL:    n_state = (r_smp == SMP_LAST) ? ST_G0 : ST_SETUP;
            ST_G0:    n_state = ST_G1;
            ST_G1:    n_state = ST_G2;
            ST_G2:    n_state = ST_G3;
            ST_G3:    n_state = ST_G4;
            ST_G4:    n_state = ST_G5;
            ST_G5:    n_state = ST_G6;
            ST_G6:    n_state = ST_G7;
            ST_G7:    n_state = ST_G8;
            ST_G8:    n_state = ST_G9;
            ST_G9:    n_state = ST_G10;
            ST_G10:   n_state = ST_G11;
            ST_G11:   n_state = ST_OUT;
            ST_OUT:   n_state = out_free ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_smp   <= SMP_CENTER;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_smp <= SMP_CENTER;
            end else if ((r_state == ST_EL) && (r_smp != SMP_LAST)) begin
                r_smp <= r_smp + 3'd1;
            end
        end
    end

    // Datapath captures; each one taken from the accumulator lands where the
    // accumulator holds the finished value of the group issued before it.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pos_x <= i_in_data.pos_x;
            r_pos_y <= i_in_data.pos_y;
            r_last  <= i_in_data.last_point;
            r_zero  <= !r_written;
        end
        unique case (r_state)
            ST_SETUP: begin
                r_dx <= (dx_s > 34'sd0) ? dx_s : '0;
                r_dy <= (dy_s > 34'sd0) ? dy_s : '0;
            end
            ST_PY1: r_fx  <= pos_clamped;
            ST_PC:  r_fy  <= pos_clamped;
            ST_BL0: r_lo  <= acc[48:0];
            ST_BL2: r_hi  <= acc[48:0];
            ST_EL:  r_elev[r_smp] <= elev_rnd[63:32];
            ST_G3:  r_gx  <= grad_cap;
            ST_G5:  r_gy  <= grad_cap;
            ST_G7:  r_p   <= pot_rnd[49:0];
            ST_G9:  r_fxo <= sat32(force_rnd);
            ST_G11: r_fyo <= sat32(force_rnd);
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Result register and batch total
    // ------------------------------------------------------------------
    logic signed [50:0] sum_wide;
    logic signed [47:0] sum_next;

    assign sum_wide = {{3{r_sum[47]}}, r_sum} + {r_p[49], r_p};
    assign sum_next = r_zero ? r_sum : sat48(sum_wide);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_sum    <= '0;
        end else if ((r_state == ST_OUT) && out_free) begin
            r_ovalid <= 1'b1;
            r_sum    <= r_last ? 48'sd0 : sum_next;
        end else if (r_ovalid && !i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_free) begin
            r_odata.force_x         <= r_zero ? 32'sd0 : r_fxo;
            r_odata.force_y         <= r_zero ? 32'sd0 : r_fyo;
            r_odata.point_potential <= r_zero ? 32'sd0 :
                                       sat32({{(ACC_W-50){r_p[49]}}, r_p});
            r_odata.total_potential <= r_last ? sum_next : 48'sd0;
            r_odata.total_valid     <= r_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_IDLE))
        else $error("height store written while a query is in work");

    a_smp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_smp <= SMP_LAST)
        else $error("sample index beyond the last sample");

    a_total_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && out_free && r_last) |=> (r_sum == 48'sd0))
        else $error("batch total not cleared after the last point");

    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.total_valid) |-> (o_out_data.total_potential == 48'sd0))
        else $error("total shown on a result that does not close a batch");

endmodule

// File: rtl/core/hgbf_mem.sv
// ----------------------------------------------------------------------------
// Height grid bilinear force: height store
// Single-port synchronous memory of grid heights with a registered read.
// ----------------------------------------------------------------------------
module hgbf_mem import hgbf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic signed [31:0]  i_wdata,
    output logic signed [31:0]  o_rdata
);

    logic signed [31:0] r_mem [MAX_ROWS*MAX_COLS];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/hgbf_mac.sv
// ----------------------------------------------------------------------------
// Height grid bilinear force: multiply-accumulate unit
// One registered 35x18 signed multiplier feeding a shifting accumulator.
// ----------------------------------------------------------------------------
module hgbf_mac import hgbf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_cmd                i_cmd,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    t_acc_op                  r_op;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_cmd.a * i_cmd.b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= ACC_HOLD;
        end else begin
            r_op <= i_cmd.op;
        end
    end

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        unique case (r_op)
            ACC_LOAD:     n_acc = prod_ext;
            ACC_ADD:      n_acc = r_acc + prod_ext;
            ACC_ADD_SR16: n_acc = r_acc + (prod_ext >>> 16);
            ACC_ADD_SL16: n_acc = r_acc + (prod_ext <<< 16);
            ACC_ADD_SL17: n_acc = r_acc + (prod_ext <<< 17);
            default:      n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule
